@@ rtl/core/ataptf_pkg.sv @@
// ----------------------------------------------------------------------------
// ATA PIO task file package
// Shared codes, register offsets and state encoding for the task file block.
// ----------------------------------------------------------------------------
package ataptf_pkg;

   // access kind
   localparam logic FUNC_READ = 1'b0;

   // task file offsets
   localparam logic [2:0] OFF_DATA       = 3'd0;
   localparam logic [2:0] OFF_COUNT      = 3'd2;
   localparam logic [2:0] OFF_LBA_LOW    = 3'd3;
   localparam logic [2:0] OFF_LBA_MID    = 3'd4;
   localparam logic [2:0] OFF_LBA_HIGH   = 3'd5;
   localparam logic [2:0] OFF_DRIVE_HEAD = 3'd6;
   localparam logic [2:0] OFF_STATUS_CMD = 3'd7;

   // status bits
   localparam logic [7:0] STS_READY = 8'h40;
   localparam logic [7:0] STS_DRQ   = 8'h08;
   localparam logic [7:0] STS_ERR   = 8'h01;

   // command opcodes
   localparam logic [7:0] OP_READ  = 8'h20;
   localparam logic [7:0] OP_WRITE = 8'h30;

   localparam logic [7:0] ERR_ABRT     = 8'h04;
   localparam logic [7:0] DH_RESET     = 8'hE0;
   localparam logic [7:0] DH_SLAVE     = 8'h10;
   localparam logic [7:0] CMD_COUNT    = 8'h01;
   localparam logic [7:0] RD_NO_DATA   = 8'hFF;

   // configuration register indexes
   localparam logic CSR_DISK_SECTORS = 1'b0;
   localparam logic CSR_DISK_PRESENT = 1'b1;

   localparam logic [6:0] DISK_SECTORS_RESET = 7'd64;

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_BUFRD   = 7'b0000100,
      S_BASE    = 7'b0001000,
      S_COPYIN  = 7'b0010000,
      S_COPYOUT = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

endpackage

@@ rtl/core/ataptf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ataptf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/ata_pio_task_file_controller_top.sv @@
// ----------------------------------------------------------------------------
// ATA PIO task file controller, LBA28, single sector
// Byte-wide bus access to a seven-register task file with a sector buffer
// and an on-chip disk store; READ/WRITE commands move one sector.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  req     | in        | req_valid/req_stall| req_func, req_reg_offset, req_write_data
//  rsp     | out       | rsp_valid/rsp_stall| rsp_read_data, rsp_handled
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
//  Register access: a request is taken in S_IDLE and answered from S_DONE; a
//  data port read passes S_BUFRD (one buffer RAM read). A READ command or the
//  write filling the last buffer byte passes S_BASE and a copy state: the shared
//  address adder walks the sector one byte per cycle between the buffer RAM and
//  the disk RAM. After reset a clearing pass zeroes the disk store and buffer,
//  one entry per cycle, with req_stall held high. A new transaction is taken
//  while a finished response waits on rsp_stall.
//
module ata_pio_task_file_controller_top #(
   parameter int SECTOR_BYTES = 512,
   parameter int DISK_SECTORS = 64
) (
   input  logic       clock,
   input  logic       reset,
   // request
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   // response
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_handled,
   // configuration
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int BA_W       = $clog2(SECTOR_BYTES);
   localparam int BI_W       = $clog2(SECTOR_BYTES + 1);
   localparam int DISK_DEPTH = DISK_SECTORS * SECTOR_BYTES;
   localparam int DA_W       = $clog2(DISK_DEPTH);
   localparam int SI_W       = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
   localparam logic [BI_W-1:0] SB_CNT  = BI_W'(SECTOR_BYTES);
   localparam logic [BI_W-1:0] SB_LAST = BI_W'(SECTOR_BYTES - 1);
   localparam logic [DA_W-1:0] DA_LAST = DA_W'(DISK_DEPTH - 1);
   localparam logic [27:0]     LBA_CAP = 28'(DISK_SECTORS);

   // sequencer
   ataptf_pkg::state_type state_ff, state_in;
   logic [BI_W-1:0] cnt_ff, cnt_in;
   logic [DA_W-1:0] clr_ff, clr_in;
   logic [DA_W-1:0] base_ff, base_in;
   logic            copy_out_ff, copy_out_in;
   logic [7:0]      res_rd_ff, res_rd_in;
   logic            res_hd_ff, res_hd_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_rd_ff, rsp_rd_in;
   logic       rsp_hd_ff, rsp_hd_in;

   // task file
   logic [7:0]      count_ff, count_in;
   logic [7:0]      lba0_ff, lba0_in;
   logic [7:0]      lba1_ff, lba1_in;
   logic [7:0]      lba2_ff, lba2_in;
   logic [7:0]      dh_ff, dh_in;
   logic [7:0]      status_ff, status_in;
   logic [7:0]      error_ff, error_in;
   logic [BI_W-1:0] bidx_ff, bidx_in;
   logic            armed_ff, armed_in;

   // configuration
   logic [6:0] dsect_ff, dsect_in;
   logic       dpres_ff, dpres_in;

   // memories
   logic            buf_we;
   logic [BA_W-1:0] buf_waddr, buf_raddr;
   logic [7:0]      buf_wdata, buf_rdata;
   logic            disk_we;
   logic [DA_W-1:0] disk_waddr, disk_raddr;
   logic [7:0]      disk_wdata, disk_rdata;

   logic [27:0]     lba;
   logic            lba_ok;
   logic            drq;
   logic            rsp_free;
   logic [BI_W-1:0] cnt_m1;
   logic [BA_W-1:0] unit_idx;
   logic [DA_W-1:0] disk_addr;

   assign lba    = {dh_ff[3:0], lba2_ff, lba1_ff, lba0_ff};
   assign lba_ok = dpres_ff && (lba < {21'd0, dsect_ff}) && (lba < LBA_CAP);
   assign drq    = (status_ff & ataptf_pkg::STS_DRQ) != 8'd0;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // shared address unit: sector base plus byte offset; the write side of a
   // copy trails the read side by one byte (registered RAM read)
   assign cnt_m1    = cnt_ff - 1'b1;
   assign unit_idx  = (state_ff == ataptf_pkg::S_COPYOUT) ? cnt_m1[BA_W-1:0]
                                                          : cnt_ff[BA_W-1:0];
   assign disk_addr = base_ff + DA_W'(unit_idx);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      base_in     = base_ff;
      copy_out_in = copy_out_ff;
      res_rd_in   = res_rd_ff;
      res_hd_in   = res_hd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in   = rsp_rd_ff;
      rsp_hd_in   = rsp_hd_ff;
      count_in    = count_ff;
      lba0_in     = lba0_ff;
      lba1_in     = lba1_ff;
      lba2_in     = lba2_ff;
      dh_in       = dh_ff;
      status_in   = status_ff;
      error_in    = error_ff;
      bidx_in     = bidx_ff;
      armed_in    = armed_ff;
      dsect_in    = dsect_ff;
      dpres_in    = dpres_ff;

      buf_we     = 1'b0;
      buf_waddr  = bidx_ff[BA_W-1:0];
      buf_wdata  = req_write_data;
      buf_raddr  = bidx_ff[BA_W-1:0];
      disk_we    = 1'b0;
      disk_waddr = disk_addr;
      disk_wdata = buf_rdata;
      disk_raddr = disk_addr;

      if (csr_we) begin
         unique case (csr_index)
            ataptf_pkg::CSR_DISK_SECTORS: dsect_in = csr_wdata;
            ataptf_pkg::CSR_DISK_PRESENT: dpres_in = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         ataptf_pkg::S_CLEAR: begin
            disk_we    = 1'b1;
            disk_waddr = clr_ff;
            disk_wdata = 8'd0;
            buf_waddr  = clr_ff[BA_W-1:0];
            buf_wdata  = 8'd0;
            buf_we     = 32'(clr_ff) < SECTOR_BYTES;
            if (clr_ff == DA_LAST) begin
               state_in = ataptf_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         ataptf_pkg::S_IDLE: begin
            if (req_valid) begin
               res_rd_in = 8'd0;
               res_hd_in = 1'b1;
               state_in  = ataptf_pkg::S_DONE;
               if (req_func == ataptf_pkg::FUNC_READ) begin
                  unique case (req_reg_offset)
                     ataptf_pkg::OFF_DATA: begin
                        if (!drq || bidx_ff >= SB_CNT) begin
                           res_rd_in = ataptf_pkg::RD_NO_DATA;
                        end else begin
                           bidx_in  = bidx_ff + 1'b1;
                           state_in = ataptf_pkg::S_BUFRD;
                           if (bidx_ff == SB_LAST) begin
                              status_in = ataptf_pkg::STS_READY;
                           end
                        end
                     end
                     ataptf_pkg::OFF_COUNT:      res_rd_in = count_ff;
                     ataptf_pkg::OFF_LBA_LOW:    res_rd_in = lba0_ff;
                     ataptf_pkg::OFF_LBA_MID:    res_rd_in = lba1_ff;
                     ataptf_pkg::OFF_LBA_HIGH:   res_rd_in = lba2_ff;
                     ataptf_pkg::OFF_DRIVE_HEAD: res_rd_in = dh_ff;
                     ataptf_pkg::OFF_STATUS_CMD: res_rd_in = status_ff;
                     default:                    res_hd_in = 1'b0;
                  endcase
               end else begin
                  unique case (req_reg_offset)
                     ataptf_pkg::OFF_DATA: begin
                        if (drq && armed_ff && bidx_ff < SB_CNT) begin
                           buf_we  = 1'b1;
                           bidx_in = bidx_ff + 1'b1;
                           if (bidx_ff == SB_LAST) begin
                              if (!lba_ok) begin
                                 status_in = ataptf_pkg::STS_READY | ataptf_pkg::STS_ERR;
                                 error_in  = ataptf_pkg::ERR_ABRT;
                                 bidx_in   = '0;
                              end else begin
                                 status_in   = ataptf_pkg::STS_READY;
                                 copy_out_in = 1'b1;
                                 state_in    = ataptf_pkg::S_BASE;
                              end
                           end
                        end
                     end
                     ataptf_pkg::OFF_COUNT:      count_in = req_write_data;
                     ataptf_pkg::OFF_LBA_LOW:    lba0_in  = req_write_data;
                     ataptf_pkg::OFF_LBA_MID:    lba1_in  = req_write_data;
                     ataptf_pkg::OFF_LBA_HIGH:   lba2_in  = req_write_data;
                     ataptf_pkg::OFF_DRIVE_HEAD: dh_in    = req_write_data;
                     ataptf_pkg::OFF_STATUS_CMD: begin
                        // command: validate, then READ starts the sector copy
                        bidx_in = '0;
                        priority if (count_ff != ataptf_pkg::CMD_COUNT ||
                                     (dh_ff & ataptf_pkg::DH_SLAVE) != 8'd0 ||
                                     !lba_ok) begin
                           status_in = ataptf_pkg::STS_READY | ataptf_pkg::STS_ERR;
                           error_in  = ataptf_pkg::ERR_ABRT;
                        end else if (req_write_data == ataptf_pkg::OP_READ) begin
                           armed_in    = 1'b0;
                           error_in    = 8'd0;
                           status_in   = ataptf_pkg::STS_READY | ataptf_pkg::STS_DRQ;
                           copy_out_in = 1'b0;
                           state_in    = ataptf_pkg::S_BASE;
                        end else if (req_write_data == ataptf_pkg::OP_WRITE) begin
                           armed_in  = 1'b1;
                           error_in  = 8'd0;
                           status_in = ataptf_pkg::STS_READY | ataptf_pkg::STS_DRQ;
                        end else begin
                           status_in = ataptf_pkg::STS_READY | ataptf_pkg::STS_ERR;
                           error_in  = ataptf_pkg::ERR_ABRT;
                        end
                     end
                     default: res_hd_in = 1'b0;
                  endcase
               end
            end
         end

         ataptf_pkg::S_BUFRD: begin
            res_rd_in = buf_rdata;
            state_in  = ataptf_pkg::S_DONE;
         end

         ataptf_pkg::S_BASE: begin
            base_in  = DA_W'(lba[SI_W-1:0]) * DA_W'(SECTOR_BYTES);
            cnt_in   = '0;
            state_in = copy_out_ff ? ataptf_pkg::S_COPYOUT : ataptf_pkg::S_COPYIN;
         end

         ataptf_pkg::S_COPYIN: begin
            // disk read at cnt, buffer write at cnt-1
            buf_waddr = cnt_m1[BA_W-1:0];
            buf_wdata = disk_rdata;
            buf_we    = cnt_ff != '0;
            if (cnt_ff == SB_CNT) begin
               state_in = ataptf_pkg::S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ataptf_pkg::S_COPYOUT: begin
            // buffer read at cnt, disk write at cnt-1
            buf_raddr = cnt_ff[BA_W-1:0];
            disk_we   = cnt_ff != '0;
            if (cnt_ff == SB_CNT) begin
               state_in = ataptf_pkg::S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ataptf_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_hd_in    = res_hd_ff;
               state_in     = ataptf_pkg::S_IDLE;
            end
         end

         default: state_in = ataptf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ataptf_pkg::S_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         copy_out_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 8'd0;
         lba0_ff      <= 8'd0;
         lba1_ff      <= 8'd0;
         lba2_ff      <= 8'd0;
         dh_ff        <= ataptf_pkg::DH_RESET;
         status_ff    <= ataptf_pkg::STS_READY;
         error_ff     <= 8'd0;
         bidx_ff      <= '0;
         armed_ff     <= 1'b0;
         dsect_ff     <= ataptf_pkg::DISK_SECTORS_RESET;
         dpres_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         copy_out_ff  <= copy_out_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         lba0_ff      <= lba0_in;
         lba1_ff      <= lba1_in;
         lba2_ff      <= lba2_in;
         dh_ff        <= dh_in;
         status_ff    <= status_in;
         error_ff     <= error_in;
         bidx_ff      <= bidx_in;
         armed_ff     <= armed_in;
         dsect_ff     <= dsect_in;
         dpres_ff     <= dpres_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      res_rd_ff <= res_rd_in;
      res_hd_ff <= res_hd_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_hd_ff <= rsp_hd_in;
   end

   ataptf_ram #(
      .WIDTH (8),
      .DEPTH (SECTOR_BYTES)
   ) u_buf_ram (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .raddr (buf_raddr),
      .rdata (buf_rdata)
   );

   ataptf_ram #(
      .WIDTH (8),
      .DEPTH (DISK_DEPTH)
   ) u_disk_ram (
      .clock (clock),
      .we    (disk_we),
      .waddr (disk_waddr),
      .wdata (disk_wdata),
      .raddr (disk_raddr),
      .rdata (disk_rdata)
   );

   assign req_stall     = state_ff != ataptf_pkg::S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_rd_ff;
   assign rsp_handled   = rsp_hd_ff;

`ifndef SYNTHESIS
   // buffer pointer never runs past the sector
   a_bidx_bound: assert property (@(posedge clock) disable iff (reset)
      bidx_ff <= SB_CNT)
      else $error("byte index past sector end");

   // DRQ only follows a successful command, which clears the error register
   a_drq_no_err: assert property (@(posedge clock) disable iff (reset)
      drq |-> error_ff == 8'd0)
      else $error("DRQ set with error pending");

   // status only takes ready, ready+error or ready+DRQ
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      status_ff == ataptf_pkg::STS_READY ||
      status_ff == (ataptf_pkg::STS_READY | ataptf_pkg::STS_ERR) ||
      status_ff == (ataptf_pkg::STS_READY | ataptf_pkg::STS_DRQ))
      else $error("illegal status value");

   // no response can exist before the clearing pass ends
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ataptf_pkg::S_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   // a copy always ends in the response state
   a_copy_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ataptf_pkg::S_COPYIN || state_ff == ataptf_pkg::S_COPYOUT) &&
      cnt_ff == SB_CNT |=> state_ff == ataptf_pkg::S_DONE)
      else $error("copy did not finish");
`endif

endmodule
